/* src/ilt_pkg.sv */
// ---------------------------------------------------------------------------
// ilt_pkg
// shared types and constants for the indexed list table and its cells
// ---------------------------------------------------------------------------
`default_nettype none

package ilt_pkg;

  // fixed field widths of the transaction ports
  localparam int CMD_W    = 3;
  localparam int POS_W    = 8;
  localparam int HANDLE_W = 32;
  localparam int FOUND_W  = 5;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;

  // parameter defaults
  localparam int DEF_CAPACITY    = 16;
  localparam int DEF_HANDLE_BITS = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_GET    = 3'd0,
    CMD_SET    = 3'd1,
    CMD_INSERT = 3'd2,
    CMD_REMOVE = 3'd3,
    CMD_PUSH   = 3'd4,
    CMD_POP    = 3'd5,
    CMD_SEARCH = 3'd6,
    CMD_CLEAR  = 3'd7
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_RANGE    = 3'd1,
    ST_FULL     = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  // what every cell of the row does on the current edge
  typedef enum logic [1:0] {
    OP_HOLD       = 2'd0,
    OP_WRITE      = 2'd1,
    OP_SHIFT_UP   = 2'd2,
    OP_SHIFT_DOWN = 2'd3
  } cell_op_t;

endpackage

`default_nettype wire

/* src/ilt_cell.sv */
// ---------------------------------------------------------------------------
// ilt_cell
// one entry of the list: holds a handle, loads it, or takes a neighbor's
// ---------------------------------------------------------------------------
`default_nettype none

module ilt_cell #(
  parameter int CELL_INDEX  = 0,
  parameter int IDX_W       = 4,
  parameter int HANDLE_BITS = 32
) (
  input  wire                      clk,
  input  wire  ilt_pkg::cell_op_t  op,
  input  wire  [IDX_W-1:0]         op_idx,
  input  wire  [HANDLE_BITS-1:0]   hdl,
  input  wire  [HANDLE_BITS-1:0]   left_val,
  input  wire  [HANDLE_BITS-1:0]   right_val,
  output logic [HANDLE_BITS-1:0]   val,
  output logic                     match
);
  import ilt_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

  logic [HANDLE_BITS-1:0] val_r;
  logic [HANDLE_BITS-1:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    unique case (op)
      OP_HOLD: val_nxt = val_r;
      OP_WRITE: begin
        if (MY_IDX == op_idx) val_nxt = hdl;
      end
      OP_SHIFT_UP: begin
        if (MY_IDX == op_idx) val_nxt = hdl;
        else if (MY_IDX > op_idx) val_nxt = left_val;
      end
      OP_SHIFT_DOWN: begin
        if (MY_IDX >= op_idx) val_nxt = right_val;
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val   = val_r;
  assign match = (val_r == hdl);

endmodule

`default_nettype wire

/* src/indexed_list_table.sv */
// ---------------------------------------------------------------------------
// indexed_list_table
// ordered list of handles in a row of cells, with get/set/insert/remove,
// push/pop, search and clear
// ---------------------------------------------------------------------------
// usage
//   input channel: in_valid/in_stall carries one command transaction
//   (in_cmd, in_position, in_handle_in); every command gives exactly one
//   result transaction on out_valid/out_stall (out_handle_out, out_found_at,
//   out_status, out_entry_count), in command order
//   a command taken into the command register moves on into the result
//   register, which drives out_valid, once that register is free
//   throughput: 1 command per cycle while out_stall holds no result; the
//   cell row shifts, loads and compares all entries in the execute stage
//   reset: rst_n low empties the list; entry contents stay undefined until
//   written and are never read while outside the live range
//   stall: while out_stall holds a waiting result, the executing command
//   waits in its register and in_stall rises; nothing is dropped
//   CAPACITY sets the number of cells, HANDLE_BITS the stored handle width
// ---------------------------------------------------------------------------
`default_nettype none

module indexed_list_table #(
  parameter int CAPACITY    = ilt_pkg::DEF_CAPACITY,
  parameter int HANDLE_BITS = ilt_pkg::DEF_HANDLE_BITS
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // command channel
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire  [ilt_pkg::CMD_W-1:0]           in_cmd,
  input  wire  [ilt_pkg::POS_W-1:0]           in_position,
  input  wire  [ilt_pkg::HANDLE_W-1:0]        in_handle_in,
  // result channel
  output logic                                out_valid,
  input  wire                                 out_stall,
  output logic [ilt_pkg::HANDLE_W-1:0]        out_handle_out,
  output logic signed [ilt_pkg::FOUND_W-1:0]  out_found_at,
  output logic [ilt_pkg::STATUS_W-1:0]        out_status,
  output logic [ilt_pkg::COUNT_W-1:0]         out_entry_count
);
  import ilt_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  // command register (execute stage)
  logic                   cmd_vld_r, cmd_vld_nxt;
  cmd_t                   cmd_r;
  logic [POS_W-1:0]       pos_r;
  logic [HANDLE_W-1:0]    hdl_r;

  // list length
  logic [CNT_W-1:0]       count_r, count_nxt;

  // result register
  logic                   out_vld_r, out_vld_nxt;
  logic [HANDLE_W-1:0]    hout_r;
  logic [FOUND_W-1:0]     found_r;
  status_t                status_r;
  logic [COUNT_W-1:0]     shown_r;

  // execute results
  logic [HANDLE_W-1:0]    hout_nxt;
  logic [FOUND_W-1:0]     found_nxt;
  status_t                status_nxt;

  logic                   accept;
  logic                   advance;

  // cell row wiring
  logic [HANDLE_BITS-1:0] hdl_st;
  cell_op_t               op;
  logic [IDX_W-1:0]       op_idx;
  logic [HANDLE_BITS-1:0] cell_val [CAPACITY];
  logic [CAPACITY-1:0]    cell_match;
  logic [CAPACITY-1:0]    live_match;

  logic                   found_any;
  logic [IDX_W-1:0]       match_idx;
  logic [IDX_W-1:0]       rd_idx;
  logic [HANDLE_BITS-1:0] rd_val;

  logic [CMP_W-1:0]       pos_ext;
  logic [CMP_W-1:0]       cnt_ext;
  logic                   in_range;
  logic                   ins_range;
  logic                   full;
  logic                   empty;

  // handshake: the command moves on once the result register is free
  assign advance  = cmd_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = cmd_vld_r && !advance;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd_vld_nxt = cmd_vld_r;
    if (accept) cmd_vld_nxt = 1'b1;
    else if (advance) cmd_vld_nxt = 1'b0;
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (advance) out_vld_nxt = 1'b1;
    else if (out_vld_r && !out_stall) out_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
      count_r   <= '0;
    end else begin
      cmd_vld_r <= cmd_vld_nxt;
      out_vld_r <= out_vld_nxt;
      count_r   <= count_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cmd_t'(in_cmd);
      pos_r <= in_position;
      hdl_r <= in_handle_in;
    end
    if (advance) begin
      hout_r   <= hout_nxt;
      found_r  <= found_nxt;
      status_r <= status_nxt;
      // clear reports the count it found, every other command the new count
      shown_r  <= (cmd_r == CMD_CLEAR) ? COUNT_W'(count_r) : COUNT_W'(count_nxt);
    end
  end

  // handle narrowed or widened to the stored width
  assign hdl_st = HANDLE_BITS'(hdl_r);

  // index checks
  assign pos_ext   = CMP_W'(pos_r);
  assign cnt_ext   = CMP_W'(count_r);
  assign in_range  = pos_ext < cnt_ext;
  assign ins_range = pos_ext <= cnt_ext;
  assign full      = (count_r == CNT_W'(CAPACITY));
  assign empty     = (count_r == '0);

  // single read port: pop reads the last entry, get and remove read position
  assign rd_idx = (cmd_r == CMD_POP) ? IDX_W'(count_r - CNT_W'(1)) : IDX_W'(pos_r);
  assign rd_val = cell_val[rd_idx];

  // first live match, lowest index wins
  always_comb begin
    found_any = 1'b0;
    match_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (live_match[i]) begin
        found_any = 1'b1;
        match_idx = IDX_W'(i);
      end
    end
  end

  // command decode
  always_comb begin
    op         = OP_HOLD;
    op_idx     = IDX_W'(pos_r);
    count_nxt  = count_r;
    hout_nxt   = '0;
    found_nxt  = '1;
    status_nxt = ST_OK;
    unique case (cmd_r)
      CMD_GET: begin
        if (!in_range) status_nxt = ST_RANGE;
        else hout_nxt = HANDLE_W'(rd_val);
      end
      CMD_SET: begin
        if (!in_range) begin
          status_nxt = ST_RANGE;
        end else begin
          op       = OP_WRITE;
          hout_nxt = HANDLE_W'(hdl_st);
        end
      end
      CMD_INSERT: begin
        if (!ins_range) begin
          status_nxt = ST_RANGE;
        end else if (full) begin
          status_nxt = ST_FULL;
        end else begin
          op        = OP_SHIFT_UP;
          count_nxt = count_r + CNT_W'(1);
          hout_nxt  = HANDLE_W'(hdl_st);
        end
      end
      CMD_REMOVE: begin
        if (!in_range) begin
          status_nxt = ST_RANGE;
        end else begin
          op        = OP_SHIFT_DOWN;
          count_nxt = count_r - CNT_W'(1);
          hout_nxt  = HANDLE_W'(rd_val);
        end
      end
      CMD_PUSH: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          op        = OP_WRITE;
          op_idx    = IDX_W'(count_r);
          count_nxt = count_r + CNT_W'(1);
          hout_nxt  = HANDLE_W'(hdl_st);
        end
      end
      CMD_POP: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          count_nxt = count_r - CNT_W'(1);
          hout_nxt  = HANDLE_W'(rd_val);
        end
      end
      CMD_SEARCH: begin
        if (found_any) found_nxt = FOUND_W'(match_idx);
        else status_nxt = ST_NOTFOUND;
      end
      CMD_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        op = OP_HOLD;
      end
    endcase
    // nothing changes unless the command actually executes this cycle
    if (!advance) begin
      op        = OP_HOLD;
      count_nxt = count_r;
    end
  end

  // row of cells; end cells see themselves as their missing neighbor
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [HANDLE_BITS-1:0] left_w;
    logic [HANDLE_BITS-1:0] right_w;

    if (g == 0) begin : g_first
      assign left_w = cell_val[g];
    end else begin : g_left
      assign left_w = cell_val[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_w = cell_val[g];
    end else begin : g_right
      assign right_w = cell_val[g+1];
    end

    ilt_cell #(
      .CELL_INDEX  (g),
      .IDX_W       (IDX_W),
      .HANDLE_BITS (HANDLE_BITS)
    ) u_cell (
      .clk       (clk),
      .op        (op),
      .op_idx    (op_idx),
      .hdl       (hdl_st),
      .left_val  (left_w),
      .right_val (right_w),
      .val       (cell_val[g]),
      .match     (cell_match[g])
    );

    // only entries below the count take part in a search
    assign live_match[g] = cell_match[g] && (CNT_W'(g) < count_r);
  end

  // result ports
  assign out_valid       = out_vld_r;
  assign out_handle_out  = hout_r;
  assign out_found_at    = signed'(found_r);
  assign out_status      = status_r;
  assign out_entry_count = shown_r;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("list count beyond capacity");

  a_exec_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_vld_r)
    else $error("executed command left no result");

  a_wait_holds_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_vld_r && !advance) |=> (cmd_vld_r && $stable(cmd_r) && $stable(pos_r)))
    else $error("waiting command changed");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && cmd_r == CMD_PUSH && !full) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("push did not grow the list");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && cmd_r == CMD_CLEAR) |=> (count_r == '0))
    else $error("clear left entries");

endmodule

`default_nettype wire
